### rtl/hdhr_pkg.sv
package hdhr_pkg;

   localparam int TEMP_W   = 13;
   localparam int DUTY_W   = 14;
   localparam int STATUS_W = 3;
   localparam int BAND_W   = 10;
   localparam int GAIN_W   = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;

   localparam logic [DUTY_W-1:0] DUTY_FULL = 14'd10000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE      = 3'd0,
      CSR_HYST_BAND   = 3'd1,
      CSR_GAIN_KP     = 3'd2,
      CSR_RAMP_STEP   = 3'd3,
      CSR_OVER_TEMP   = 3'd4,
      CSR_VALID_MIN   = 3'd5,
      CSR_VALID_MAX   = 3'd6
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_REGULATING = 3'd0,
      STATUS_DISABLED   = 3'd1,
      STATUS_OVER_TEMP  = 3'd2,
      STATUS_INVALID    = 3'd3,
      STATUS_ABOVE_OFF  = 3'd4
   } status_type;

   typedef struct packed {
      logic                      enable;
      logic [BAND_W-1:0]         dead_band;
      logic [GAIN_W-1:0]         gain_kp;
      logic [DUTY_W-1:0]         ramp_step;
      logic signed [TEMP_W-1:0]  over_temp_limit;
      logic signed [TEMP_W-1:0]  valid_min;
      logic signed [TEMP_W-1:0]  valid_max;
   } cfg_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      status_type        status;
      logic              hold_last;
   } result_type;

endpackage

### rtl/hdhr_if.sv
interface hdhr_req_if import hdhr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] measured_temp;
   logic signed [TEMP_W-1:0] target_temp;

   modport source (output valid, measured_temp, target_temp, input ready);
   modport sink   (input valid, measured_temp, target_temp, output ready);
endinterface

interface hdhr_rsp_if import hdhr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DUTY_W-1:0]   duty;
   logic [STATUS_W-1:0] status;

   modport source (output valid, duty, status, input ready);
   modport sink   (input valid, duty, status, output ready);
endinterface

interface hdhr_csr_if import hdhr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/hdhr_law.sv
module hdhr_law import hdhr_pkg::*; (
   input  cfg_type                  cfg,
   input  logic signed [TEMP_W-1:0] meas,
   input  logic signed [TEMP_W-1:0] targ,
   input  logic [DUTY_W-1:0]        last_duty,
   output result_type               result
);

   logic signed [TEMP_W:0]       err;
   logic signed [TEMP_W:0]       band;
   logic [TEMP_W+GAIN_W-1:0]     prod;
   logic [TEMP_W+GAIN_W-4:0]     prod_shr;
   logic [DUTY_W-1:0]            demand;
   logic signed [DUTY_W:0]       delta;
   logic signed [DUTY_W:0]       step;

   assign err      = (TEMP_W+1)'(targ) - (TEMP_W+1)'(meas);
   assign band     = $signed({{(TEMP_W+1-BAND_W){1'b0}}, cfg.dead_band});
   // err is non-negative wherever the product is used
   assign prod     = err[TEMP_W-1:0] * cfg.gain_kp;
   assign prod_shr = prod[TEMP_W+GAIN_W-1:3];
   assign delta    = $signed({1'b0, demand}) - $signed({1'b0, last_duty});
   assign step     = $signed({1'b0, cfg.ramp_step});

   always_comb begin
      if (err >= band) begin
         if (prod_shr > (TEMP_W+GAIN_W-3)'(DUTY_FULL)) begin
            demand = DUTY_FULL;
         end else begin
            demand = prod_shr[DUTY_W-1:0];
         end
      end else begin
         demand = last_duty;
      end
   end

   always_comb begin
      result.hold_last = 1'b0;
      result.duty      = '0;
      result.status    = STATUS_REGULATING;
      if (!cfg.enable) begin
         result.status    = STATUS_DISABLED;
         result.hold_last = 1'b1;
      end else if (meas >= cfg.over_temp_limit) begin
         result.status = STATUS_OVER_TEMP;
      end else if (meas < cfg.valid_min || meas > cfg.valid_max) begin
         result.status = STATUS_INVALID;
      end else if (err <= -band) begin
         result.status = STATUS_ABOVE_OFF;
      end else if (delta > step) begin
         result.duty = last_duty + cfg.ramp_step;
      end else if (delta < -step) begin
         result.duty = last_duty - cfg.ramp_step;
      end else begin
         result.duty = demand;
      end
   end

endmodule

### rtl/heater_duty_hysteresis_ramp.sv
// Heater duty controller with hysteresis dead band and slew limit.
// req_ch: one transfer per control tick carries measured_temp and target_temp.
// rsp_ch: one transfer per request carries duty (0..10000, 0.01 %) and status.
// csr_ch: register writes, index 0..6, always ready; write only while idle.
// A request is captured in the input register, computed from it through the
// control law, and its response is registered once the output register is free.
// Throughput: one request per cycle while rsp_ch does not stall; the loop on the
// last duty register closes combinationally through the control law.
// When rsp_ch stalls, the response holds and one more request is taken into
// the input register; req_ch.ready then drops until the response moves.
// Reset clears both pipeline stages, sets the last duty to zero and loads
// the register defaults (disabled, band 32, gain 125, ramp 10, limit 1360,
// valid range -640..1920).
module heater_duty_hysteresis_ramp import hdhr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   hdhr_req_if.sink    req_ch,
   hdhr_rsp_if.source  rsp_ch,
   hdhr_csr_if.sink    csr_ch
);

   cfg_type                  cfg_ff, cfg_in;
   logic                     in_valid_ff, in_valid_in;
   logic signed [TEMP_W-1:0] meas_ff, meas_in;
   logic signed [TEMP_W-1:0] targ_ff, targ_in;
   logic                     out_valid_ff, out_valid_in;
   logic [DUTY_W-1:0]        duty_ff, duty_in;
   status_type               status_ff, status_in;
   logic [DUTY_W-1:0]        last_duty_ff, last_duty_in;
   result_type               result;
   logic                     out_advance;
   logic                     in_advance;

   hdhr_law u_law (
      .cfg       (cfg_ff),
      .meas      (meas_ff),
      .targ      (targ_ff),
      .last_duty (last_duty_ff),
      .result    (result)
   );

   assign csr_ch.ready  = 1'b1;
   assign out_advance   = !out_valid_ff || rsp_ch.ready;
   assign in_advance    = in_valid_ff && out_advance;
   assign req_ch.ready  = !in_valid_ff || out_advance;

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.duty   = duty_ff;
   assign rsp_ch.status = status_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_ENABLE:    cfg_in.enable          = csr_ch.data[0];
            CSR_HYST_BAND: cfg_in.dead_band       = csr_ch.data[BAND_W-1:0];
            CSR_GAIN_KP:   cfg_in.gain_kp         = csr_ch.data[GAIN_W-1:0];
            CSR_RAMP_STEP: cfg_in.ramp_step       = csr_ch.data[DUTY_W-1:0];
            CSR_OVER_TEMP: cfg_in.over_temp_limit = $signed(csr_ch.data[TEMP_W-1:0]);
            CSR_VALID_MIN: cfg_in.valid_min       = $signed(csr_ch.data[TEMP_W-1:0]);
            CSR_VALID_MAX: cfg_in.valid_max       = $signed(csr_ch.data[TEMP_W-1:0]);
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      meas_in     = meas_ff;
      targ_in     = targ_ff;
      if (req_ch.ready) begin
         in_valid_in = req_ch.valid;
         meas_in     = req_ch.measured_temp;
         targ_in     = req_ch.target_temp;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      duty_in      = duty_ff;
      status_in    = status_ff;
      last_duty_in = last_duty_ff;
      if (out_advance) begin
         out_valid_in = in_valid_ff;
      end
      if (in_advance) begin
         duty_in   = result.duty;
         status_in = result.status;
         if (!result.hold_last) begin
            last_duty_in = result.duty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable          <= 1'b0;
         cfg_ff.dead_band       <= 10'd32;
         cfg_ff.gain_kp         <= 10'd125;
         cfg_ff.ramp_step       <= 14'd10;
         cfg_ff.over_temp_limit <= 13'sd1360;
         cfg_ff.valid_min       <= -13'sd640;
         cfg_ff.valid_max       <= 13'sd1920;
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
         last_duty_ff           <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         last_duty_ff <= last_duty_in;
      end
   end

   always_ff @(posedge clock) begin
      meas_ff   <= meas_in;
      targ_ff   <= targ_in;
      duty_ff   <= duty_in;
      status_ff <= status_in;
   end

endmodule
